### hdl/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg
// Shared constants, codes and control types of the sparse residual core.
// ----------------------------------------------------------------------------
package srr_pkg;

  // model store geometry
  localparam int MODEL_DEPTH = 4096;
  localparam int MODEL_AW    = $clog2(MODEL_DEPTH);

  // fixed point: Q16.16 values, Q32.32 products and squares
  localparam int FRAC_BITS = 16;

  // field widths
  localparam int CMD_W   = 2;
  localparam int INDEX_W = 12;
  localparam int VAL_W   = 32;
  localparam int WIDE_W  = 64;
  localparam int IDX_EXT_W = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENTRY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EMPTY = 2'd2;

  // saturation bounds
  localparam logic signed [WIDE_W-1:0] ACC_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] ACC_MIN = {1'b1, {(WIDE_W-1){1'b0}}};
  localparam logic signed [WIDE_W-1:0] Q_LIM   = 64'sh0000_0002_0000_0000;
  localparam logic signed [VAL_W-1:0]  RES_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0]  RES_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // controller to datapath
  typedef struct packed {
    logic ram_we;
    logic ram_re;
    logic capture;
    logic mul_en;
    logic acc_en;
    logic res_en;
    logic sq_en;
    logic sum_en;
  } srr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic row_last;
    logic out_busy;
  } srr_sts_t;

endpackage

### hdl/srr_ram.sv
// ----------------------------------------------------------------------------
// srr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/srr_ctrl.sv
// ----------------------------------------------------------------------------
// srr_ctrl
// Sequencer: accepts one beat at a time and steps the datapath through
// multiply, accumulate and the row close (residual, square, sum).
// ----------------------------------------------------------------------------
module srr_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [srr_pkg::CMD_W-1:0] cmd,
  input  srr_pkg::srr_sts_t        sts,
  output srr_pkg::srr_cmd_t        ctl
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_RES  = 3'd3;
  localparam logic [2:0] S_SQ   = 3'd4;
  localparam logic [2:0] S_SUM  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // commands and next state
  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            srr_pkg::CMD_LOAD: begin
              ctl.ram_we = 1'b1;
            end
            srr_pkg::CMD_ENTRY: begin
              ctl.ram_re  = 1'b1;
              ctl.capture = 1'b1;
              state_next  = S_MUL;
            end
            srr_pkg::CMD_EMPTY: begin
              ctl.capture = 1'b1;
              state_next  = S_RES;
            end
            default: begin
              // unused code: dropped
            end
          endcase
        end
      end
      S_MUL: begin
        ctl.mul_en = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        ctl.acc_en = 1'b1;
        state_next = sts.row_last ? S_RES : S_IDLE;
      end
      S_RES: begin
        ctl.res_en = 1'b1;
        state_next = S_SQ;
      end
      S_SQ: begin
        ctl.sq_en  = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        // wait for the output register to free up
        if (!sts.out_busy) begin
          ctl.sum_en = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  // datapath steps never overlap
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.mul_en, ctl.acc_en, ctl.res_en, ctl.sq_en, ctl.sum_en}))
    else $error("srr_ctrl: overlapping datapath steps");

  // a result is never committed over an unread one
  a_sum_free: assert property (@(posedge clk) disable iff (rst)
    ctl.sum_en |-> !sts.out_busy)
    else $error("srr_ctrl: sum committed while output busy");

  // an entry always goes multiply then accumulate
  a_mul_acc: assert property (@(posedge clk) disable iff (rst)
    ctl.mul_en |=> ctl.acc_en)
    else $error("srr_ctrl: multiply not followed by accumulate");
`endif

endmodule

### hdl/srr_dp.sv
// ----------------------------------------------------------------------------
// srr_dp
// Datapath: model store, product, saturating row accumulator, residual,
// square, running sum and the output register.
// ----------------------------------------------------------------------------
module srr_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  srr_pkg::srr_cmd_t                  ctl,
  output srr_pkg::srr_sts_t                  sts,
  input  logic [srr_pkg::INDEX_W-1:0]        index,
  input  logic signed [srr_pkg::VAL_W-1:0]   value,
  input  logic signed [srr_pkg::VAL_W-1:0]   rhs,
  input  logic                               row_last,
  input  logic                               matrix_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [srr_pkg::VAL_W-1:0]   residual,
  output logic [srr_pkg::WIDE_W-1:0]         square_sum,
  output logic                               overflow,
  output logic                               last
);

  localparam int VW = srr_pkg::VAL_W;
  localparam int WW = srr_pkg::WIDE_W;
  localparam int RW = 36;

  // index handling
  logic [srr_pkg::IDX_EXT_W-1:0] idx_ext;
  logic [srr_pkg::MODEL_AW-1:0]  addr;
  logic                          idx_ok;

  assign idx_ext = srr_pkg::IDX_EXT_W'(index);
  assign addr    = idx_ext[srr_pkg::MODEL_AW-1:0];
  assign idx_ok  = (idx_ext < srr_pkg::IDX_EXT_W'(srr_pkg::MODEL_DEPTH));

  // model store
  logic [VW-1:0] ram_rdata;

  srr_ram #(
    .WIDTH(VW),
    .DEPTH(srr_pkg::MODEL_DEPTH)
  ) u_model (
    .clk  (clk),
    .we   (ctl.ram_we && idx_ok),
    .waddr(addr),
    .wdata(value),
    .re   (ctl.ram_re),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  // beat capture
  logic signed [VW-1:0] coef;
  logic signed [VW-1:0] rhs_q;
  logic                 row_last_q;
  logic                 final_q;
  logic                 col_ok;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      coef       <= value;
      rhs_q      <= rhs;
      row_last_q <= row_last;
      final_q    <= matrix_last;
      col_ok     <= idx_ok;
    end
  end

  assign sts.row_last = row_last_q;
  assign sts.out_busy = out_valid && !out_ready;

  // product
  logic signed [VW-1:0] xval;
  logic signed [WW-1:0] prod_w;
  logic signed [WW-1:0] prod;

  assign xval   = col_ok ? signed'(ram_rdata) : '0;
  assign prod_w = coef * xval;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= prod_w;
    end
  end

  // saturating accumulate
  logic signed [WW-1:0] acc;
  logic signed [WW-1:0] acc_sum;
  logic                 acc_of;

  assign acc_sum = acc + prod;
  assign acc_of  = (acc[WW-1] == prod[WW-1]) && (acc_sum[WW-1] != acc[WW-1]);

  // residual: floor shift, clamp, subtract, saturate
  logic signed [WW-1:0] q_sh;
  logic signed [WW-1:0] q_cl;
  logic signed [RW-1:0] r_wide;
  logic signed [VW-1:0] r_sat;
  logic                 r_of;

  assign q_sh = acc >>> srr_pkg::FRAC_BITS;

  always_comb begin
    if (q_sh > srr_pkg::Q_LIM) begin
      q_cl = srr_pkg::Q_LIM;
    end else if (q_sh < -srr_pkg::Q_LIM) begin
      q_cl = -srr_pkg::Q_LIM;
    end else begin
      q_cl = q_sh;
    end
    r_wide = RW'(rhs_q) - RW'(q_cl);
    if (r_wide > RW'(srr_pkg::RES_MAX)) begin
      r_sat = srr_pkg::RES_MAX;
      r_of  = 1'b1;
    end else if (r_wide < RW'(srr_pkg::RES_MIN)) begin
      r_sat = srr_pkg::RES_MIN;
      r_of  = 1'b1;
    end else begin
      r_sat = VW'(r_wide);
      r_of  = 1'b0;
    end
  end

  logic signed [VW-1:0] res_q;

  always_ff @(posedge clk) begin
    if (ctl.res_en) begin
      res_q <= r_sat;
    end
  end

  // square
  logic signed [WW-1:0] sq_w;
  logic [WW-1:0]        sq;

  assign sq_w = res_q * res_q;

  always_ff @(posedge clk) begin
    if (ctl.sq_en) begin
      sq <= unsigned'(sq_w);
    end
  end

  // running sum, saturating at all ones
  logic [WW-1:0] sum;
  logic [WW:0]   sum_w;
  logic [WW-1:0] sum_new;
  logic          ovf;
  logic          ovf_new;

  assign sum_w   = {1'b0, sum} + {1'b0, sq};
  assign sum_new = sum_w[WW] ? '1 : sum_w[WW-1:0];
  assign ovf_new = ovf || sum_w[WW];

  // accumulator, sum and sticky flag
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      sum <= '0;
      ovf <= 1'b0;
    end else begin
      if (ctl.acc_en) begin
        acc <= acc_of ? (acc[WW-1] ? srr_pkg::ACC_MIN : srr_pkg::ACC_MAX) : acc_sum;
        if (acc_of) begin
          ovf <= 1'b1;
        end
      end
      if (ctl.res_en) begin
        acc <= '0;
        if (r_of) begin
          ovf <= 1'b1;
        end
      end
      if (ctl.sum_en) begin
        if (final_q) begin
          sum <= '0;
          ovf <= 1'b0;
        end else begin
          sum <= sum_new;
          ovf <= ovf_new;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      residual   <= res_q;
      square_sum <= sum_new;
      overflow   <= ovf_new;
      last       <= final_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.sum_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // closing a row leaves the accumulator clear
  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    ctl.res_en |=> (acc == '0))
    else $error("srr_dp: accumulator not cleared at row close");

  // a waiting result is held by the output register
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(residual) && $stable(square_sum) && $stable(last)))
    else $error("srr_dp: pending result changed");

  // a final row clears the running sum after its result
  a_final_clear: assert property (@(posedge clk) disable iff (rst)
    (ctl.sum_en && final_q) |=> ((sum == '0) && !ovf))
    else $error("srr_dp: sum not cleared after final row");
`endif

endmodule

### hdl/sparse_residual_roughness_core.sv
// ----------------------------------------------------------------------------
// sparse_residual_roughness_core
// Streams sparse matrix rows against a stored model vector and returns the
// per-row residual rhs - A*x with a running saturating sum of its squares.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------
//   input   | in_valid / in_ready  | cmd, index, value, rhs, row_last, matrix_last
//   output  | out_valid / out_ready| residual, square_sum, overflow, last
//
// A load beat is a model store write at accept. A nonzero entry steps through
// accept with store read, multiply and accumulate; the registered store read
// and the product register set these steps. A row close adds residual, square
// and sum: an empty row is accept then those; a row-ending entry runs both sets.
// Reset clears the accumulator, running sum and sticky flag; the store is
// not cleared. One result waits in the output register while the next beat
// is taken; a second row close stalls only while that result is unread.
//
module sparse_residual_roughness_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [srr_pkg::CMD_W-1:0]          cmd,
  input  logic [srr_pkg::INDEX_W-1:0]        index,
  input  logic signed [srr_pkg::VAL_W-1:0]   value,
  input  logic signed [srr_pkg::VAL_W-1:0]   rhs,
  input  logic                               row_last,
  input  logic                               matrix_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [srr_pkg::VAL_W-1:0]   residual,
  output logic [srr_pkg::WIDE_W-1:0]         square_sum,
  output logic                               overflow,
  output logic                               last
);

  srr_pkg::srr_cmd_t ctl;
  srr_pkg::srr_sts_t sts;

  srr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd     (cmd),
    .sts     (sts),
    .ctl     (ctl)
  );

  srr_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .index      (index),
    .value      (value),
    .rhs        (rhs),
    .row_last   (row_last),
    .matrix_last(matrix_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .residual   (residual),
    .square_sum (square_sum),
    .overflow   (overflow),
    .last       (last)
  );

endmodule
